FILE: src/bel_pkg.sv
// shared constants, types and op codes of the button event and led panel
package bel_pkg;

  localparam int NUM_BOARDS  = 2;
  localparam int NUM_BUTTONS = 4 * NUM_BOARDS;
  localparam int BRD_W       = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;
  localparam int BTN_W       = $clog2(NUM_BUTTONS);
  localparam int THR_W       = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd1000;

  typedef enum logic [2:0] {
    OP_SAMPLE    = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_CLEAR_ALL = 3'd2,
    OP_SET_LED   = 3'd3,
    OP_SET_ALL   = 3'd4,
    OP_QUERY     = 3'd5
  } op_t;

  // one memory row per board: previous button sample and press times
  typedef struct packed {
    logic [3:0]       last;
    logic [3:0][31:0] press;
  } row_t;

  localparam row_t RESET_ROW = '{last: 4'hF, press: '0};

endpackage

FILE: src/bel_cmd_if.sv
// command channel: one sample, clear, led or query transaction
interface bel_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic       board;
  logic [7:0] port_value;
  logic [31:0] now_ms;
  logic [2:0] button;
  logic [2:0] clear_mask;
  logic       led_on;

  modport source (output valid, op, board, port_value, now_ms, button, clear_mask,
                  led_on, input ready);
  modport sink   (input valid, op, board, port_value, now_ms, button, clear_mask,
                  led_on, output ready);
endinterface

FILE: src/bel_status_if.sv
// status channel: one board report per command transaction
interface bel_status_if;
  logic       valid;
  logic       ready;
  logic       report_board;
  logic [3:0] button_levels;
  logic [3:0] down_flags;
  logic [3:0] up_flags;
  logic [3:0] long_flags;
  logic [7:0] led_port;

  modport source (output valid, report_board, button_levels, down_flags, up_flags,
                  long_flags, led_port, input ready);
  modport sink   (input valid, report_board, button_levels, down_flags, up_flags,
                  long_flags, led_port, output ready);
endinterface

FILE: src/bel_ram.sv
// generic single-write, single-read ram with registered read data
module bel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/button_event_led_panel.sv
// top level: button edge detection, sticky flags and led port per board
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+-----------------------------------------
//   cmd      | in  | valid / ready  | op, board, port_value, now_ms, button,
//            |     |                | clear_mask, led_on
//   status   | out | valid / ready  | report_board, button_levels, down_flags,
//            |     |                | up_flags, long_flags, led_port
//   cfg      | in  | cfg_we         | cfg_data = long_press_ms
//
// one transaction per cycle while the status is not stalled; a status passes these steps:
// row read from the board ram at the accepting edge, then update, write-back and output register
// back-to-back rows to the same board are forwarded from the write port
// reset is synchronous, rows read as reset value until first written
// a stalled status holds one command in the update stage before ready drops
module button_event_led_panel (
  input  logic                        clk,
  input  logic                        rst,
  bel_cmd_if.sink                     cmd,
  bel_status_if.source                status,
  input  logic                        cfg_we,
  input  logic [bel_pkg::THR_W-1:0]   cfg_data
);
  import bel_pkg::*;

  logic [THR_W-1:0] long_press_ms;

  // flag and led state, cleared in bulk so kept in flops
  logic [NUM_BUTTONS-1:0] down_q, up_q, long_q, led_q;
  logic [NUM_BUTTONS-1:0] down_next, up_next, long_next, led_next;
  logic [NUM_BOARDS-1:0]  row_valid;

  // request side
  logic             in_fire;
  logic [BRD_W-1:0] in_brd, btn_brd, in_row;
  logic             in_ok;

  // update stage
  logic             s1_v;
  logic [2:0]       s1_op;
  logic [BRD_W-1:0] s1_row;
  logic [3:0]       s1_nib;
  logic [31:0]      s1_now;
  logic [2:0]       s1_btn;
  logic             s1_ok;
  logic [2:0]       s1_mask;
  logic             s1_on;
  logic             s1_row_valid;
  logic             s1_hit;
  row_t             s1_fwd;
  logic             s1_fire;

  row_t             ram_rdata, cur_row, new_row;
  logic             wr_req, wr_en;

  logic [3:0] rep_down, rep_up, rep_long, rep_led;

  logic       out_v;

  assign in_brd  = (NUM_BOARDS > 1) ? BRD_W'(cmd.board) : '0;
  assign btn_brd = BRD_W'(cmd.button >> 2);
  assign in_ok   = 7'(cmd.button) < 7'(NUM_BUTTONS);
  assign in_row  = ((cmd.op == OP_CLEAR || cmd.op == OP_SET_LED) && in_ok) ? btn_brd : in_brd;

  assign s1_fire   = s1_v && (!out_v || status.ready);
  assign cmd.ready = !s1_v || s1_fire;
  assign in_fire   = cmd.valid && cmd.ready;
  assign wr_en     = s1_fire && wr_req;

  bel_ram #(.WIDTH($bits(row_t)), .DEPTH(NUM_BOARDS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_row),
    .wdata (new_row),
    .re    (in_fire),
    .raddr (in_row),
    .rdata (ram_rdata)
  );

  assign cur_row = s1_hit ? s1_fwd : (s1_row_valid ? ram_rdata : RESET_ROW);

  always_comb begin
    logic [BTN_W-1:0] k;
    logic [31:0]      held;
    new_row   = cur_row;
    down_next = down_q;
    up_next   = up_q;
    long_next = long_q;
    led_next  = led_q;
    wr_req    = 1'b0;
    k         = BTN_W'(s1_btn);
    held      = '0;
    case (s1_op)
      OP_SAMPLE: begin
        wr_req       = 1'b1;
        new_row.last = s1_nib;
        for (int i = 0; i < 4; i++) begin
          k    = BTN_W'({s1_row, 2'(i)});
          held = s1_now - cur_row.press[i];
          if (!s1_nib[i] && cur_row.last[i]) begin
            down_next[k]     = 1'b1;
            new_row.press[i] = s1_now;
          end
          if (s1_nib[i] && !cur_row.last[i]) begin
            up_next[k] = 1'b1;
            if (held > {16'h0, long_press_ms}) begin
              long_next[k]     = 1'b1;
              new_row.press[i] = '0;
            end
          end
        end
      end
      OP_CLEAR: begin
        if (s1_ok) begin
          if (s1_mask[0]) down_next[k] = 1'b0;
          if (s1_mask[1]) up_next[k] = 1'b0;
          if (s1_mask[2]) begin
            long_next[k]                = 1'b0;
            new_row.press[s1_btn[1:0]]  = '0;
            wr_req                      = 1'b1;
          end
        end
      end
      OP_CLEAR_ALL: begin
        down_next = '0;
        up_next   = '0;
        long_next = '0;
      end
      OP_SET_LED: begin
        if (s1_ok) led_next[k] = s1_on;
      end
      OP_SET_ALL: begin
        led_next = {NUM_BUTTONS{s1_on}};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    logic [BTN_W-1:0] j;
    rep_down = '0;
    rep_up   = '0;
    rep_long = '0;
    rep_led  = '0;
    for (int i = 0; i < 4; i++) begin
      j           = BTN_W'({s1_row, 2'(i)});
      rep_down[i] = down_next[j];
      rep_up[i]   = up_next[j];
      rep_long[i] = long_next[j];
      rep_led[i]  = led_next[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= THR_RESET;
      down_q        <= '0;
      up_q          <= '0;
      long_q        <= '0;
      led_q         <= '0;
      row_valid     <= '0;
      s1_v          <= 1'b0;
      out_v         <= 1'b0;
    end else begin
      if (cfg_we) begin
        long_press_ms <= cfg_data;
      end
      if (s1_fire) begin
        down_q <= down_next;
        up_q   <= up_next;
        long_q <= long_next;
        led_q  <= led_next;
      end
      if (wr_en) begin
        row_valid[s1_row] <= 1'b1;
      end
      if (in_fire) begin
        s1_v <= 1'b1;
      end else if (s1_fire) begin
        s1_v <= 1'b0;
      end
      if (s1_fire) begin
        out_v <= 1'b1;
      end else if (status.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op        <= cmd.op;
      s1_row       <= in_row;
      s1_nib       <= cmd.port_value[3:0];
      s1_now       <= cmd.now_ms;
      s1_btn       <= cmd.button;
      s1_ok        <= in_ok;
      s1_mask      <= cmd.clear_mask;
      s1_on        <= cmd.led_on;
      s1_row_valid <= row_valid[in_row];
      // ram reads old contents when written at the same edge
      s1_hit       <= wr_en && (s1_row == in_row);
      s1_fwd       <= new_row;
    end
    if (s1_fire) begin
      status.report_board  <= s1_row[0];
      status.button_levels <= ~new_row.last;
      status.down_flags    <= rep_down;
      status.up_flags      <= rep_up;
      status.long_flags    <= rep_long;
      status.led_port      <= {~rep_led, 4'hF};
    end
  end

  assign status.valid = out_v;

endmodule

FILE: src/bel_checker.sv
// port-level checks of the button event and led panel, bound to the top level
module bel_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_ready,
  input logic       status_valid,
  input logic       status_ready,
  input logic [7:0] led_port,
  input logic [3:0] down_flags
);

  // a stalled status transaction keeps valid high
  assert property (@(posedge clk) disable iff (rst)
    status_valid && !status_ready |=> status_valid)
    else $error("status valid dropped while stalled");

  // a stalled status transaction keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    status_valid && !status_ready |=> $stable(led_port) && $stable(down_flags))
    else $error("status payload changed while stalled");

  // ready only drops when a finished status is stuck at the output
  assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> status_valid && !status_ready)
    else $error("command stalled without a blocked status");

  // low nibble of the led port always drives ones
  assert property (@(posedge clk) disable iff (rst)
    status_valid |-> led_port[3:0] == 4'hF)
    else $error("led port low nibble not all ones");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !status_valid)
    else $error("status valid right after reset");

endmodule

bind button_event_led_panel bel_checker u_bel_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_ready    (cmd.ready),
  .status_valid (status.valid),
  .status_ready (status.ready),
  .led_port     (status.led_port),
  .down_flags   (status.down_flags)
);
